[src/srtf_pkg.sv]
// srtf_pkg: shared constants, result codes and controller/datapath interface types
// for the SRTF tick scheduler. No dependencies.
package srtf_pkg;

	localparam int JOB_SLOTS_DEF = 16;
	localparam int TIME_BITS_DEF = 16;
	localparam int BURST_W       = 16;
	localparam int LIMIT_W       = 16;
	localparam int SUM_W         = 32;
	localparam int STATUS_W      = 3;

	localparam logic [LIMIT_W-1:0] TIME_LIMIT_RST = 16'd100;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED  = 3'd0,
		ST_REJECT = 3'd1,
		ST_RAN    = 3'd2,
		ST_DONE   = 3'd3,
		ST_IDLE   = 3'd4,
		ST_STOP   = 3'd5
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;     // capture request payload, clear scan result
		logic tick_mode;  // scan looks for least remaining time (else free slot)
		logic scan;       // read table entry at scan index
		logic fetch;      // read table entry of the chosen slot
		logic calc1;
		logic calc2;
		logic calc3;
		logic add_wr;     // place job or reject
		logic res_idle;   // idle tick result, time advances
		logic res_stop;   // stopped result
		logic out_load;   // move result into output register
	} srtf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic stopped;
		logic best_vld;
	} srtf_sts_t;

endpackage

[src/srtf_ctrl.sv]
// srtf_ctrl: request sequencer for the SRTF tick scheduler; slot scan counter,
// output valid flag. Depends on srtf_pkg.
module srtf_ctrl #(
	parameter int JOB_SLOTS = srtf_pkg::JOB_SLOTS_DEF,
	localparam int SW = $clog2(JOB_SLOTS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  srtf_pkg::srtf_sts_t sts,
	output srtf_pkg::srtf_cmd_t cmd,
	output logic [SW-1:0]       scan_idx
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SCAN  = 10'b0000000010,
		S_DRAIN = 10'b0000000100,
		S_PICK  = 10'b0000001000,
		S_ADD   = 10'b0000010000,
		S_FETCH = 10'b0000100000,
		S_CALC1 = 10'b0001000000,
		S_CALC2 = 10'b0010000000,
		S_CALC3 = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	localparam logic [SW-1:0] LAST_SLOT = SW'(JOB_SLOTS - 1);

	state_t        state_q, state_d;
	logic [SW-1:0] cnt_q, cnt_d;
	logic          kind_q, kind_d;
	logic          m_tvalid_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign scan_idx = cnt_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		kind_d  = kind_q;
		cmd     = '0;
		cmd.tick_mode = kind_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					kind_d     = s_tuser;
					cnt_d      = '0;
					if (s_tuser && sts.stopped) begin
						cmd.res_stop = 1'b1;
						state_d      = S_OUT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (cnt_q == LAST_SLOT) begin
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + SW'(1);
				end
			end
			S_DRAIN: state_d = S_PICK;
			S_PICK: begin
				if (!kind_q) begin
					state_d = S_ADD;
				end else if (sts.best_vld) begin
					state_d = S_FETCH;
				end else begin
					cmd.res_idle = 1'b1;
					state_d      = S_OUT;
				end
			end
			S_ADD: begin
				cmd.add_wr = 1'b1;
				state_d    = S_OUT;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_CALC1;
			end
			S_CALC1: begin
				cmd.calc1 = 1'b1;
				state_d   = S_CALC2;
			end
			S_CALC2: begin
				cmd.calc2 = 1'b1;
				state_d   = S_CALC3;
			end
			S_CALC3: begin
				cmd.calc3 = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			kind_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			kind_q  <= kind_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// a request is only taken with the sequencer at rest
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == S_SCAN || state_q == S_OUT))
		else $error("accept left from a busy state");

	// scan always ends on the last slot
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> ($past(cnt_q) == LAST_SLOT))
		else $error("scan ended early");

	// a stopped tick never touches the table scan
	a_stop_path: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_stop |=> (state_q == S_OUT))
		else $error("stopped tick did not go to output");

endmodule

[src/srtf_dp.sv]
// srtf_dp: datapath of the SRTF tick scheduler: job table memory, active bits,
// time, limit register, waiting total, scan compare and output register. Depends on srtf_pkg.
module srtf_dp #(
	parameter int JOB_SLOTS = srtf_pkg::JOB_SLOTS_DEF,
	parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF,
	localparam int SW = $clog2(JOB_SLOTS),
	localparam int OUT_BITS = SW + 3 * TIME_BITS + srtf_pkg::SUM_W,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  srtf_pkg::srtf_cmd_t                cmd,
	input  logic [SW-1:0]                      scan_idx,
	output srtf_pkg::srtf_sts_t                sts,
	input  logic [srtf_pkg::BURST_W-1:0]       burst_in,
	input  logic                               cfg_we,
	input  logic [srtf_pkg::LIMIT_W-1:0]       cfg_data,
	output logic [srtf_pkg::STATUS_W-1:0]      m_tuser,
	output logic [OUT_W-1:0]                   m_tdata
);

	localparam int BW    = srtf_pkg::BURST_W;
	localparam int MW    = TIME_BITS + 2 * BW;
	localparam int CMP_W = (TIME_BITS > srtf_pkg::LIMIT_W) ? TIME_BITS : srtf_pkg::LIMIT_W;
	localparam int SUMW  = srtf_pkg::SUM_W;

	// table word: {arrival, original burst, remaining}
	logic [MW-1:0]              mem_q [JOB_SLOTS];
	logic [MW-1:0]              rdata_q;
	logic                       mem_we, mem_re;
	logic [SW-1:0]              raddr;
	logic [MW-1:0]              wdata;

	logic [JOB_SLOTS-1:0]       active_q;
	logic [BW-1:0]              burst_q;
	logic [TIME_BITS-1:0]       time_q;
	logic [srtf_pkg::LIMIT_W-1:0] limit_q;
	logic [SUMW-1:0]            sum_q;

	logic                       rd_vld_s1;
	logic [SW-1:0]              rd_idx_s1;
	logic                       best_vld_q;
	logic [SW-1:0]              best_idx_q;
	logic [BW-1:0]              best_rem_q;

	logic [BW-1:0]              rem_new_q;
	logic [TIME_BITS-1:0]       comp_q, turn_q, wait_q;

	srtf_pkg::status_t          res_st_q;
	logic [SW-1:0]              res_slot_q;
	logic [TIME_BITS-1:0]       res_comp_q, res_turn_q, res_wait_q;

	logic [srtf_pkg::STATUS_W-1:0] out_st_q;
	logic [OUT_W-1:0]           out_q;

	logic [BW-1:0]              rd_rem;
	logic                       cand_tick, cand_add, cand;
	logic                       job_done;
	logic [SUMW:0]              sum_ext;

	assign rd_rem    = rdata_q[BW-1:0];
	assign cand_tick = active_q[rd_idx_s1] && (!best_vld_q || rd_rem < best_rem_q);
	assign cand_add  = !active_q[rd_idx_s1] && !best_vld_q && (burst_q != '0);
	assign cand      = rd_vld_s1 && (cmd.tick_mode ? cand_tick : cand_add);
	assign job_done  = (rem_new_q == '0);
	assign sum_ext   = {1'b0, sum_q} + (SUMW + 1)'(wait_q);

	assign sts.stopped  = (CMP_W'(time_q) >= CMP_W'(limit_q)) || (time_q == '1);
	assign sts.best_vld = best_vld_q;

	assign mem_re = cmd.scan || cmd.fetch;
	assign raddr  = cmd.fetch ? best_idx_q : scan_idx;
	assign mem_we = (cmd.add_wr && best_vld_q) || cmd.calc2;
	assign wdata  = cmd.add_wr ? {time_q, burst_q, burst_q} : {rdata_q[MW-1:BW], rem_new_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[best_idx_q] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx;
		if (cand) begin
			best_idx_q <= rd_idx_s1;
			best_rem_q <= rd_rem;
		end
		if (cmd.accept) begin
			burst_q <= burst_in;
		end
		if (cmd.calc1) begin
			rem_new_q <= rd_rem - BW'(1);
			comp_q    <= time_q + TIME_BITS'(1);
			turn_q    <= time_q + TIME_BITS'(1) - rdata_q[MW-1:2*BW];
		end
		if (cmd.calc2) begin
			wait_q <= turn_q - TIME_BITS'(rdata_q[2*BW-1:BW]);
		end
		if (cmd.out_load) begin
			out_st_q <= res_st_q;
			out_q    <= OUT_W'({sum_q, res_wait_q, res_turn_q, res_comp_q, res_slot_q});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_stop || cmd.res_idle) begin
			res_st_q   <= cmd.res_stop ? srtf_pkg::ST_STOP : srtf_pkg::ST_IDLE;
			res_slot_q <= '0;
			res_comp_q <= '0;
			res_turn_q <= '0;
			res_wait_q <= '0;
		end else if (cmd.add_wr) begin
			res_st_q   <= best_vld_q ? srtf_pkg::ST_ADDED : srtf_pkg::ST_REJECT;
			res_slot_q <= best_vld_q ? best_idx_q : '0;
			res_comp_q <= '0;
			res_turn_q <= '0;
			res_wait_q <= '0;
		end else if (cmd.calc3) begin
			res_st_q   <= job_done ? srtf_pkg::ST_DONE : srtf_pkg::ST_RAN;
			res_slot_q <= best_idx_q;
			res_comp_q <= job_done ? comp_q : '0;
			res_turn_q <= job_done ? turn_q : '0;
			res_wait_q <= job_done ? wait_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= '0;
			time_q     <= '0;
			limit_q    <= srtf_pkg::TIME_LIMIT_RST;
			sum_q      <= '0;
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.accept) begin
				best_vld_q <= 1'b0;
			end else if (cand) begin
				best_vld_q <= 1'b1;
			end
			if (cmd.add_wr && best_vld_q) begin
				active_q[best_idx_q] <= 1'b1;
			end
			if (cmd.calc2 && job_done) begin
				active_q[best_idx_q] <= 1'b0;
			end
			if (cmd.res_idle) begin
				time_q <= time_q + TIME_BITS'(1);
			end
			if (cmd.calc2) begin
				time_q <= comp_q;
			end
			if (cmd.calc3 && job_done) begin
				sum_q <= sum_ext[SUMW] ? '1 : sum_ext[SUMW-1:0];
			end
		end
	end

	assign m_tuser = out_st_q;
	assign m_tdata = out_q;

	a_add_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.add_wr && best_vld_q) |=> active_q[$past(best_idx_q)])
		else $error("placed job not marked active");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.calc2 && job_done) |=> !active_q[$past(best_idx_q)])
		else $error("completed job still active");

	a_sum_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (sum_q >= $past(sum_q)))
		else $error("waiting total decreased");

	a_time_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (time_q == $past(time_q) || time_q == $past(time_q) + TIME_BITS'(1)))
		else $error("time moved by more than one");

endmodule

[src/srtf_tick_scheduler.sv]
// srtf_tick_scheduler: top level of the shortest-remaining-time-first scheduler.
// Instantiates srtf_ctrl and srtf_dp; depends on srtf_pkg.
//
// One request is handled at a time. A tick scans every job slot through the
// single-port job table, one slot per cycle. A tick that finds the time at or
// past time_limit, or at its largest value, skips the scan and gives a stop result.
// A result is moved into the output register only once an earlier result there
// has been taken.
// A finished result sits in the output register, so the next request can be
// accepted while it waits to be taken. Input tuser is the kind (0 add, 1 tick)
// and tdata the burst; output tuser is the status.
// time_limit may be written at any time the block is idle; its reset is 100.
module srtf_tick_scheduler #(
	parameter int JOB_SLOTS = srtf_pkg::JOB_SLOTS_DEF,
	parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF,
	localparam int SW = $clog2(JOB_SLOTS),
	localparam int OUT_BITS = SW + 3 * TIME_BITS + srtf_pkg::SUM_W,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [srtf_pkg::BURST_W-1:0]       s_tdata,   // job_burst
	input  logic                               s_tuser,   // kind
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// slot, completion_time, turnaround_time, waiting_time, total_waiting, zero pad
	output logic [OUT_W-1:0]                   m_tdata,
	output logic [srtf_pkg::STATUS_W-1:0]      m_tuser,   // status
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [srtf_pkg::LIMIT_W-1:0]       cfg_data   // time_limit
);

	srtf_pkg::srtf_cmd_t cmd;
	srtf_pkg::srtf_sts_t sts;
	logic [SW-1:0]       scan_idx;

	assign cfg_ready = 1'b1;

	srtf_ctrl #(
		.JOB_SLOTS(JOB_SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd),
		.scan_idx (scan_idx)
	);

	srtf_dp #(
		.JOB_SLOTS(JOB_SLOTS),
		.TIME_BITS(TIME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.scan_idx (scan_idx),
		.sts      (sts),
		.burst_in (s_tdata),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata)
	);

endmodule

[tb/srtf_tick_scheduler_test.sv]
// srtf_tick_scheduler_test: self-checking testbench for the SRTF tick scheduler.
// Drives add/tick requests and time_limit writes, predicts each result in a scoreboard
// model and checks it field by field. Depends on srtf_pkg and srtf_tick_scheduler.
module srtf_tick_scheduler_test;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_TICK = 1'b1;
	localparam int   SLOTS       = 16;
	localparam int   QUIET_LIMIT = 1000;

	typedef struct {
		srtf_pkg::status_t status;
		logic [3:0]  slot;
		logic [15:0] completion;
		logic [15:0] turnaround;
		logic [15:0] waiting;
		logic [31:0] total_waiting;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// scheduler model state
	logic [15:0] now_tick = '0;
	logic [15:0] limit_reg = srtf_pkg::TIME_LIMIT_RST;
	bit          job_used [SLOTS];
	bit          job_done [SLOTS];
	logic [15:0] job_arrival [SLOTS];
	logic [15:0] job_burst_orig [SLOTS];
	logic [15:0] job_left [SLOTS];
	logic [31:0] wait_total = '0;

	sched_result_t expected_results[$];
	int          error_count = 0;
	int          quiet_cycles = 0;
	bit          steady = 1'b0;

	srtf_tick_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic sched_result_t schedule_step(input logic kind, input logic [15:0] burst);
		sched_result_t r;
		int pick;
		logic [15:0] comp, turn, waited;
		logic [32:0] sum;
		r.status = srtf_pkg::ST_ADDED;
		r.slot = '0;
		r.completion = '0;
		r.turnaround = '0;
		r.waiting = '0;
		pick = -1;
		if (kind == KIND_ADD) begin
			if (burst != 0)
				for (int i = 0; i < SLOTS; i++)
					if (pick < 0 && (!job_used[i] || job_done[i]))
						pick = i;
			if (pick < 0) begin
				r.status = srtf_pkg::ST_REJECT;
			end else begin
				job_used[pick] = 1'b1;
				job_done[pick] = 1'b0;
				job_arrival[pick] = now_tick;
				job_burst_orig[pick] = burst;
				job_left[pick] = burst;
				r.slot = 4'(pick);
			end
		end else if (now_tick >= limit_reg || now_tick == 16'hFFFF) begin
			r.status = srtf_pkg::ST_STOP;
		end else begin
			for (int i = 0; i < SLOTS; i++)
				if (job_used[i] && !job_done[i] && (pick < 0 || job_left[i] < job_left[pick]))
					pick = i;
			if (pick < 0) begin
				now_tick = now_tick + 16'd1;
				r.status = srtf_pkg::ST_IDLE;
			end else begin
				job_left[pick] = job_left[pick] - 16'd1;
				r.slot = 4'(pick);
				if (job_left[pick] == 0) begin
					comp = now_tick + 16'd1;
					turn = comp - job_arrival[pick];
					waited = turn - job_burst_orig[pick];
					job_done[pick] = 1'b1;
					sum = {1'b0, wait_total} + 33'(waited);
					wait_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					now_tick = comp;
					r.status = srtf_pkg::ST_DONE;
					r.completion = comp;
					r.turnaround = turn;
					r.waiting = waited;
				end else begin
					now_tick = now_tick + 16'd1;
					r.status = srtf_pkg::ST_RAN;
				end
			end
		end
		r.total_waiting = wait_total;
		return r;
	endfunction

	function automatic logic [15:0] random_burst();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 16'd0;
		if (r < 8)
			return 16'($urandom_range(65535));
		return 16'($urandom_range(8, 1));
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	task automatic send_request(input logic kind, input logic [15:0] burst);
		int gap;
		sched_result_t want;
		gap = 0;
		if (!steady && $urandom_range(99) < 15)
			gap = $urandom_range(4, 1);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= burst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		want = schedule_step(kind, burst);
		expected_results.insert(expected_results.size(), want);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_time_limit(input logic [15:0] value);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		limit_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int count);
		for (int n = 0; n < count; n++)
			if ($urandom_range(99) < 20)
				send_request(KIND_ADD, random_burst());
			else
				send_request(KIND_TICK, 16'($urandom_range(65535)));
	endtask

	// zero burst, idle tick, completion, slot reuse, tie on remaining time, huge burst
	task automatic test_directed_basics();
		send_request(KIND_ADD, 16'd0);
		send_request(KIND_TICK, 16'hFFFF);
		send_request(KIND_ADD, 16'd1);
		send_request(KIND_TICK, 16'd0);
		send_request(KIND_ADD, 16'd2);
		send_request(KIND_ADD, 16'd2);
		repeat (4) send_request(KIND_TICK, 16'd0);
		send_request(KIND_ADD, 16'hFFFF);
	endtask

	task automatic test_table_full();
		repeat (SLOTS - 1) send_request(KIND_ADD, 16'd1);
		send_request(KIND_ADD, 16'd3);
	endtask

	task automatic test_time_limit();
		set_time_limit(16'd0);
		send_request(KIND_TICK, 16'd0);
		send_request(KIND_ADD, 16'd5);
		set_time_limit(now_tick);
		send_request(KIND_TICK, 16'd0);
		set_time_limit(16'hFFFF);
	endtask

	task automatic test_random_mix();
		run_random(250);
	endtask

	task automatic test_limit_reached();
		set_time_limit(now_tick + 16'($urandom_range(60, 20)));
		run_random(150);
	endtask

	task automatic test_random_limit();
		set_time_limit(16'($urandom_range(65535)));
		run_random(150);
	endtask

	task automatic test_back_to_back();
		set_time_limit(16'hFFFF);
		steady = 1'b1;
		run_random(100);
		steady = 1'b0;
	endtask

	always @(negedge clk)
		m_tready <= steady || $urandom_range(99) >= 15;

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request pending: status %0d", m_tuser);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, m_tuser);
				check_field("slot", want.slot, m_tdata[3:0]);
				check_field("completion_time", want.completion, m_tdata[19:4]);
				check_field("turnaround_time", want.turnaround, m_tdata[35:20]);
				check_field("waiting_time", want.waiting, m_tdata[51:36]);
				check_field("total_waiting", want.total_waiting, m_tdata[83:52]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_basics();
		test_table_full();
		test_time_limit();
		test_random_mix();
		test_limit_reached();
		test_random_limit();
		test_back_to_back();
		drain_results();
		repeat (30) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
